### rtl/pwqs_pkg.sv
`timescale 1ns / 1ps
// pwqs_pkg: shared types, codes and widths for the priority wait queue semaphore
// no dependencies; used by the interfaces, the queue cell and the top level

package pwqs_pkg;

    // fixed field widths
    localparam int KIND_W  = 2;
    localparam int TID_W   = 3;
    localparam int CPRIO_W = 8;
    localparam int COUNT_W = 16;

    // defaults for the top level parameters
    localparam int DEF_MAX_WAITERS   = 8;
    localparam int DEF_PRIORITY_BITS = 8;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CWAIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CSIGNAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BWAIT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BSIGNAL = 2'd3;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // saturation limits of the count
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    // operation broadcast to every queue cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

### rtl/pwqs_if.sv
`timescale 1ns / 1ps
// pwqs_if: valid/ready channels for request, response and count configuration
// depends on pwqs_pkg for field widths

interface pwqs_req_if import pwqs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [TID_W-1:0]    thread_id;
    logic [CPRIO_W-1:0]  caller_priority;

    modport source (output valid, kind, thread_id, caller_priority, input ready);
    modport sink   (input valid, kind, thread_id, caller_priority, output ready);
endinterface

interface pwqs_rsp_if import pwqs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       caller_blocked;
    logic                       woke_valid;
    logic [TID_W-1:0]           woke_thread;
    logic                       preempt;
    logic signed [COUNT_W-1:0]  count_after;
    logic                       status;

    modport source (output valid, caller_blocked, woke_valid, woke_thread, preempt,
                    count_after, status, input ready);
    modport sink   (input valid, caller_blocked, woke_valid, woke_thread, preempt,
                    count_after, status, output ready);
endinterface

interface pwqs_cfg_if import pwqs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COUNT_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/pwqs_cell.sv
`timescale 1ns / 1ps
// pwqs_cell: one slot of the sorted wait queue, shifts toward its neighbors
// depends on pwqs_pkg for the control struct and the thread id width

module pwqs_cell import pwqs_pkg::*; #(
    parameter int PW = DEF_PRIORITY_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [TID_W-1:0]  i_new_id,
    input  logic [PW-1:0]     i_new_prio,
    input  logic              i_left_keep,
    input  logic              i_left_valid,
    input  logic [TID_W-1:0]  i_left_id,
    input  logic [PW-1:0]     i_left_prio,
    input  logic              i_right_valid,
    input  logic [TID_W-1:0]  i_right_id,
    input  logic [PW-1:0]     i_right_prio,
    output logic              o_valid,
    output logic [TID_W-1:0]  o_id,
    output logic [PW-1:0]     o_prio,
    output logic              o_keep
);

    logic              r_valid;
    logic [TID_W-1:0]  r_id;
    logic [PW-1:0]     r_prio;
    logic              n_valid;
    logic [TID_W-1:0]  n_id;
    logic [PW-1:0]     n_prio;

    // entry stays in place on insert when it ranks at or above the newcomer
    assign o_keep = r_valid && (r_prio <= i_new_prio);

    // next slot contents: hold, take the new word, shift right or shift left
    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_prio  = r_prio;
        if (i_ctl.ins && !o_keep) begin
            if (i_left_keep) begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_prio  = i_new_prio;
            end else begin
                n_valid = i_left_valid;
                n_id    = i_left_id;
                n_prio  = i_left_prio;
            end
        end else if (i_ctl.pop) begin
            n_valid = i_right_valid;
            n_id    = i_right_id;
            n_prio  = i_right_prio;
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_prio  = r_prio;

endmodule

### rtl/priority_wait_queue_semaphore.sv
`timescale 1ns / 1ps
// priority_wait_queue_semaphore: counting/binary semaphore with sorted wait queue
// depends on pwqs_pkg, the pwqs channel interfaces and pwqs_cell
//
// Usage:
//   i_req carries one request word (kind, thread_id, caller_priority); o_rsp
//   returns exactly one response word per request; i_cfg loads the count.
//   A request is captured into the single decode/update stage; when it leaves
//   that stage its response word is registered in the response register,
//   which drives o_rsp.valid. The stage reads the head cell and drives the
//   row of queue cells, which insert in priority order or shift out the
//   head. i_req.ready is low while a request is in that stage, so a new
//   request is not taken until the last one has left the stage.
//   The response register frees the request side: a new request is taken
//   while a response waits; if o_rsp.ready stays low the finished request
//   holds in the update stage and i_req.ready stays low until it moves on.
//   Reset (synchronous, active low) empties the queue and sets the count to
//   zero. A write on i_cfg is always taken and loads the count at once; write
//   it only while the block is idle.

module priority_wait_queue_semaphore import pwqs_pkg::*; #(
    parameter int MAX_WAITERS   = DEF_MAX_WAITERS,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pwqs_req_if.sink   i_req,
    pwqs_rsp_if.source o_rsp,
    pwqs_cfg_if.sink   i_cfg
);

    localparam int N  = MAX_WAITERS;
    localparam int PW = PRIORITY_BITS;

    // request stage
    logic                       r_busy;
    logic [KIND_W-1:0]          r_kind;
    logic [TID_W-1:0]           r_tid;
    logic [PW-1:0]              r_prio;
    logic signed [COUNT_W-1:0]  r_count;
    logic signed [COUNT_W-1:0]  n_count;

    // response register
    logic                       r_out_valid;
    logic                       r_blocked;
    logic                       r_woke;
    logic [TID_W-1:0]           r_woke_id;
    logic                       r_preempt;
    logic signed [COUNT_W-1:0]  r_count_after;
    logic                       r_status;

    // decode results
    logic                       n_blocked;
    logic                       n_woke;
    logic [TID_W-1:0]           n_woke_id;
    logic                       n_preempt;
    logic                       n_status;
    t_cell_ctl                  w_op;
    t_cell_ctl                  w_ctl;
    logic                       w_fire;
    logic signed [COUNT_W-1:0]  w_dec;
    logic signed [COUNT_W-1:0]  w_inc;
    logic                       w_full;

    // queue cell row
    logic              w_valid [N];
    logic [TID_W-1:0]  w_id    [N];
    logic [PW-1:0]     w_cprio [N];
    logic              w_keep  [N];

    assign w_fire    = r_busy && (!r_out_valid || o_rsp.ready);
    assign w_full    = w_valid[N-1];
    assign i_req.ready = !r_busy;
    assign i_cfg.ready = 1'b1;

    // request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.valid && !r_busy) begin
            r_busy <= 1'b1;
        end else if (w_fire) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && !r_busy) begin
            r_kind <= i_req.kind;
            r_tid  <= i_req.thread_id;
            r_prio <= PW'(i_req.caller_priority);
        end
    end

    // saturating neighbors of the count
    assign w_dec = (r_count == COUNT_MIN) ? r_count : r_count - 16'sd1;
    assign w_inc = (r_count == COUNT_MAX) ? r_count : r_count + 16'sd1;

    // request decode against the count and the head cell
    always_comb begin
        n_count   = r_count;
        n_blocked = 1'b0;
        n_woke    = 1'b0;
        n_status  = STATUS_OK;
        w_op      = '0;
        case (r_kind)
            KIND_CWAIT: begin
                if (w_dec[COUNT_W-1]) begin
                    if (w_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        n_blocked = 1'b1;
                        w_op.ins  = 1'b1;
                        n_count   = w_dec;
                    end
                end else begin
                    n_count = w_dec;
                end
            end
            KIND_CSIGNAL: begin
                n_count = w_inc;
                if ((w_inc[COUNT_W-1] || (w_inc == '0)) && w_valid[0]) begin
                    n_woke   = 1'b1;
                    w_op.pop = 1'b1;
                end
            end
            KIND_BWAIT: begin
                if (r_count == '0) begin
                    if (w_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        n_blocked = 1'b1;
                        w_op.ins  = 1'b1;
                    end
                end
                n_count = '0;
            end
            KIND_BSIGNAL: begin
                if (w_valid[0]) begin
                    n_woke   = 1'b1;
                    w_op.pop = 1'b1;
                    n_count  = '0;
                end else begin
                    n_count = 16'sd1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_woke_id = n_woke ? w_id[0] : '0;
        n_preempt = n_woke && (r_prio > w_cprio[0]);
    end

    assign w_ctl = w_fire ? w_op : '0;

    // count register, loaded by configuration writes (which win) and by request updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg.valid) begin
            r_count <= i_cfg.data;
        end else if (w_fire) begin
            r_count <= n_count;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_blocked     <= n_blocked;
            r_woke        <= n_woke;
            r_woke_id     <= n_woke_id;
            r_preempt     <= n_preempt;
            r_count_after <= n_count;
            r_status      <= n_status;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.caller_blocked = r_blocked;
    assign o_rsp.woke_valid     = r_woke;
    assign o_rsp.woke_thread    = r_woke_id;
    assign o_rsp.preempt        = r_preempt;
    assign o_rsp.count_after    = r_count_after;
    assign o_rsp.status         = r_status;

    // row of queue cells, head at index zero
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic              w_lkeep;
        logic              w_lvalid;
        logic [TID_W-1:0]  w_lid;
        logic [PW-1:0]     w_lprio;
        logic              w_rvalid;
        logic [TID_W-1:0]  w_rid;
        logic [PW-1:0]     w_rprio;

        if (g == 0) begin : g_head
            assign w_lkeep  = 1'b1;
            assign w_lvalid = 1'b0;
            assign w_lid    = '0;
            assign w_lprio  = '0;
        end else begin : g_mid
            assign w_lkeep  = w_keep[g-1];
            assign w_lvalid = w_valid[g-1];
            assign w_lid    = w_id[g-1];
            assign w_lprio  = w_cprio[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign w_rvalid = 1'b0;
            assign w_rid    = '0;
            assign w_rprio  = '0;
        end else begin : g_body
            assign w_rvalid = w_valid[g+1];
            assign w_rid    = w_id[g+1];
            assign w_rprio  = w_cprio[g+1];
        end

        pwqs_cell #(
            .PW (PW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_id      (r_tid),
            .i_new_prio    (r_prio),
            .i_left_keep   (w_lkeep),
            .i_left_valid  (w_lvalid),
            .i_left_id     (w_lid),
            .i_left_prio   (w_lprio),
            .i_right_valid (w_rvalid),
            .i_right_id    (w_rid),
            .i_right_prio  (w_rprio),
            .o_valid       (w_valid[g]),
            .o_id          (w_id[g]),
            .o_prio        (w_cprio[g]),
            .o_keep        (w_keep[g])
        );
    end

    // a refused request only happens with every cell occupied
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_status == STATUS_FULL) |-> w_full)
        else $error("queue full flagged with a free cell");

    // a blocked caller leaves a nonempty queue behind
    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> w_valid[0])
        else $error("insert left the head cell empty");

    // popping always frees the tail cell
    a_pop_frees_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> !w_valid[N-1])
        else $error("pop left the tail cell occupied");

    // a response never both blocks the caller and wakes a waiter
    a_block_or_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_blocked && r_woke))
        else $error("response both blocked and woke");

endmodule
